@@ rtl/sent_packet_window_tracker_macros.svh @@
// assertion macros shared by the tracker rtl
// expects clk and arst_n in the scope of each use
`ifndef SENT_PACKET_WINDOW_TRACKER_MACROS_SVH
`define SENT_PACKET_WINDOW_TRACKER_MACROS_SVH

// property that holds at every clock edge out of reset
`define SPWT_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition in one cycle implies a result in the next
`define SPWT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/spwt_pkg.sv @@
// shared types, constants and helpers of the sent packet window tracker
// no dependencies
package spwt_pkg;

	localparam int RING_DEPTH_DEF = 1024;
	localparam int CHUNK_BITS     = 15;
	localparam int SEQ_W          = 16;
	localparam int LEN_W          = 16;
	localparam int STAMP_W        = 63;
	localparam int BYTE_W         = 32;
	localparam int PKT_W          = 11;
	localparam int IN_DATA_W      = 128;
	localparam int OUT_DATA_W     = 208;
	localparam int APB_ADDR_W     = 3;
	localparam logic [31:0] WINDOW_RESET = 32'd1000000000;
	localparam logic [SEQ_W-1:0] SERIAL_HALF_M1 = 16'h7FFF;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CHUNK  = 2'd1,
		OP_UPDATE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH,
		ST_SENT_RD, ST_SENT_EV,
		ST_FL_RD, ST_FL_EV,
		ST_ACK_REF, ST_ACK_THR, ST_ACK_RD, ST_ACK_EV,
		ST_CH_BIT, ST_CH_RD, ST_CH_EV,
		ST_DONE
	} state_t;

	// one ring entry as stored
	typedef struct packed {
		logic               disc;
		logic [STAMP_W-1:0] stamp;
		logic [LEN_W-1:0]   len;
		logic [SEQ_W-1:0]   seq;
	} entry_t;

	// x serially below y, modulo 2^16, half distance counts as equal
	function automatic logic serial_lt(input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] y);
		logic [SEQ_W-1:0] d;
		d = y - x;
		return (d != '0) && (d <= SERIAL_HALF_M1);
	endfunction

endpackage

@@ rtl/spwt_entry_ram.sv @@
// single port write, single port read ring memory, registered read data
// depends on spwt_pkg for the entry type
module spwt_entry_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  spwt_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output spwt_pkg::entry_t rdata
);
	import spwt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sent_packet_window_tracker.sv @@
// top level of the sent packet window tracker: sequencer, totals, config port
// depends on spwt_pkg, spwt_entry_ram and sent_packet_window_tracker_macros.svh
//
// usage:
//   input items arrive on s_tvalid/s_tready with the op code in s_tuser and
//   the operands in s_tdata; each accepted item gives exactly one result item
//   on m_tvalid/m_tready carrying all running totals and the overflow flag.
//   window_length is written through the apb port at byte address 0 while idle.
// steps of each op, from accept to result valid:
//   add:    writes the entry and retires each entry that leaves the sent
//           window, or flags overflow and writes nothing when the ring is full
//   update: moves entries to the acked window, then retires acked expiries
//   chunk:  for each covered sequence not set in the bitvector, probes entries
//           until a hit or both lists end; skipped when end is not above start
//   no-op:  goes straight to the result
//   every walk step is a memory read state then an evaluate state on the single
//   ring memory, which also sets the pace; one item is worked at a time and
//   the next item can be taken while the result is valid.
// reset clears pointers, totals and the highest discarded sequence, and loads
//   the default window; ring contents need no clearing since only live slots
//   are read.
// a stalled receiver: the finished result sits in the output register while
//   the next item is taken and worked; that item waits in its final state
//   until the output register is free.
`include "sent_packet_window_tracker_macros.svh"
module sent_packet_window_tracker #(
	parameter int RING_DEPTH = spwt_pkg::RING_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now, seq, payload bytes, end_seq, bitvector, zero pad
	input  logic [spwt_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [1:0]                      s_tuser,
	// item out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// sent_bytes_window, sent_packets_window, acked_bytes_window,
	// acked_packets_window, flight_bytes, flight_packets, discarded_bytes,
	// discarded_packets, goodput_bytes, overflow, zero pad
	output logic [spwt_pkg::OUT_DATA_W-1:0] m_tdata,
	// config
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spwt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import spwt_pkg::*;

	localparam int SLOT_W  = $clog2(RING_DEPTH);
	localparam int PTR_W   = $clog2(2 * RING_DEPTH);
	localparam int PTR_MAX = 2 * RING_DEPTH - 1;
	localparam int BIT_W   = $clog2(CHUNK_BITS + 1);

	// pointer helpers, pointers count modulo twice the ring depth
	function automatic logic [PTR_W-1:0] age(input logic [PTR_W-1:0] w,
			input logic [PTR_W-1:0] p);
		logic [PTR_W:0] d;
		d = {1'b0, w} - {1'b0, p};
		if (d[PTR_W]) begin
			d = d + (PTR_W+1)'(2 * RING_DEPTH);
		end
		return d[PTR_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] q;
		q = (p >= PTR_W'(RING_DEPTH)) ? p - PTR_W'(RING_DEPTH) : p;
		return q[SLOT_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(PTR_MAX)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] prv(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(PTR_MAX) : p - 1'b1;
	endfunction

	state_t state_q, state_d;

	// config
	logic [31:0] window_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? window_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			window_q <= pwdata;
		end
	end

	// latched item
	op_t                op_q;
	logic [STAMP_W-1:0] now_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [LEN_W-1:0]   len_q;
	logic [SEQ_W-1:0]   end_q;
	logic [CHUNK_BITS-1:0] bv_q;

	// ring pointers and totals
	logic [PTR_W-1:0]  wp_q, swh_q, fh_q, awh_q, scan_q;
	logic              scan_acked_q;
	logic [BYTE_W-1:0] sent_b_q, acked_b_q, flight_b_q, disc_b_q;
	logic [PKT_W-1:0]  sent_p_q, acked_p_q, flight_p_q, disc_p_q;
	logic [SEQ_W-1:0]  hd_q;
	logic [SEQ_W-1:0]  cur_q;
	logic [BIT_W-1:0]  bit_q;
	logic [STAMP_W-1:0] thr_q;
	logic              thr_ok_q;
	logic              ovf_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign s_tready = (state_q == ST_IDLE);

	// ring memory
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr, mem_raddr;
	entry_t            mem_wdata, rd;

	spwt_entry_ram #(
		.DEPTH(RING_DEPTH),
		.AW   (SLOT_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	// decisions on the read entry
	logic [PTR_W-1:0] age_awh, age_swh, live;
	logic full_c, expired_c, fl_stop_c, hit_c, mark_c, out_free_c, chunk_end_c;

	assign age_awh     = age(wp_q, awh_q);
	assign age_swh     = age(wp_q, swh_q);
	assign live        = (age_awh > age_swh) ? age_awh : age_swh;
	assign full_c      = live >= PTR_W'(RING_DEPTH);
	assign expired_c   = thr_ok_q && (rd.stamp <= thr_q);
	assign fl_stop_c   = serial_lt(seq_q, rd.seq);
	assign hit_c       = (rd.seq == cur_q);
	assign mark_c      = hit_c && !rd.disc && !serial_lt(rd.seq, hd_q);
	assign out_free_c  = !m_tvalid_q || m_tready;
	assign chunk_end_c = (bit_q == BIT_W'(CHUNK_BITS)) || (cur_q == end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = slot(wp_q);
		mem_wdata = '{disc: 1'b0, stamp: now_q, len: len_q, seq: seq_q};
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (op_q)
					OP_ADD: begin
						if (full_c) begin
							state_d = ST_DONE;
						end else begin
							mem_we  = 1'b1;
							state_d = ST_SENT_RD;
						end
					end
					OP_CHUNK:  state_d = serial_lt(seq_q, end_q) ? ST_CH_BIT : ST_DONE;
					OP_UPDATE: state_d = ST_FL_RD;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_SENT_RD: begin
				mem_raddr = slot(swh_q);
				state_d   = (swh_q == wp_q) ? ST_DONE : ST_SENT_EV;
			end
			ST_SENT_EV: begin
				state_d = expired_c ? ST_SENT_RD : ST_DONE;
			end
			ST_FL_RD: begin
				mem_raddr = slot(fh_q);
				state_d   = (fh_q == wp_q) ? ST_ACK_REF : ST_FL_EV;
			end
			ST_FL_EV: begin
				state_d = fl_stop_c ? ST_ACK_REF : ST_FL_RD;
			end
			ST_ACK_REF: begin
				mem_raddr = slot(prv(fh_q));
				state_d   = (awh_q == fh_q) ? ST_DONE : ST_ACK_THR;
			end
			ST_ACK_THR: begin
				state_d = ST_ACK_RD;
			end
			ST_ACK_RD: begin
				mem_raddr = slot(awh_q);
				state_d   = (awh_q == fh_q) ? ST_DONE : ST_ACK_EV;
			end
			ST_ACK_EV: begin
				state_d = expired_c ? ST_ACK_RD : ST_DONE;
			end
			ST_CH_BIT: begin
				if (chunk_end_c) begin
					state_d = ST_DONE;
				end else if (!bv_q[bit_q]) begin
					state_d = ST_CH_RD;
				end
			end
			ST_CH_RD: begin
				mem_raddr = slot(scan_q);
				if (scan_acked_q && scan_q == fh_q) begin
					state_d = ST_CH_BIT;
				end else if (scan_acked_q || scan_q != wp_q) begin
					state_d = ST_CH_EV;
				end
			end
			ST_CH_EV: begin
				if (mark_c) begin
					mem_we    = 1'b1;
					mem_waddr = slot(scan_q);
					mem_wdata = '{disc: 1'b1, stamp: rd.stamp, len: rd.len, seq: rd.seq};
				end
				state_d = hit_c ? ST_CH_BIT : ST_CH_RD;
			end
			ST_DONE: begin
				if (out_free_c) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// latched item fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q  <= op_t'(s_tuser);
			now_q <= s_tdata[62:0];
			seq_q <= s_tdata[78:63];
			len_q <= s_tdata[94:79];
			end_q <= s_tdata[110:95];
			bv_q  <= s_tdata[125:111];
		end
	end

	// pointers, totals and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			swh_q      <= '0;
			fh_q       <= '0;
			awh_q      <= '0;
			sent_b_q   <= '0;
			acked_b_q  <= '0;
			flight_b_q <= '0;
			disc_b_q   <= '0;
			sent_p_q   <= '0;
			acked_p_q  <= '0;
			flight_p_q <= '0;
			disc_p_q   <= '0;
			hd_q       <= '0;
			ovf_q      <= 1'b0;
			scan_q       <= '0;
			scan_acked_q <= 1'b0;
			cur_q      <= '0;
			bit_q      <= '0;
			thr_q      <= '0;
			thr_ok_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ovf_q <= 1'b0;
				end
				ST_DISPATCH: begin
					cur_q <= seq_q;
					bit_q <= '0;
					if (op_q == OP_ADD) begin
						if (full_c) begin
							ovf_q <= 1'b1;
						end else begin
							wp_q       <= nxt(wp_q);
							flight_b_q <= flight_b_q + BYTE_W'(len_q);
							flight_p_q <= flight_p_q + 1'b1;
							sent_b_q   <= sent_b_q + BYTE_W'(len_q);
							sent_p_q   <= sent_p_q + 1'b1;
							// expiry threshold for the sent window walk
							thr_q    <= now_q - STAMP_W'(window_q);
							thr_ok_q <= now_q >= STAMP_W'(window_q);
						end
					end
				end
				ST_SENT_EV: begin
					if (expired_c) begin
						sent_b_q <= sent_b_q - BYTE_W'(rd.len);
						sent_p_q <= sent_p_q - 1'b1;
						swh_q    <= nxt(swh_q);
						// freed when already out of the acked window
						if (age_swh > age_awh && rd.disc) begin
							disc_b_q <= disc_b_q - BYTE_W'(rd.len);
							disc_p_q <= disc_p_q - 1'b1;
						end
					end
				end
				ST_FL_EV: begin
					if (!fl_stop_c) begin
						flight_b_q <= flight_b_q - BYTE_W'(rd.len);
						flight_p_q <= flight_p_q - 1'b1;
						acked_b_q  <= acked_b_q + BYTE_W'(rd.len);
						acked_p_q  <= acked_p_q + 1'b1;
						fh_q       <= nxt(fh_q);
					end
				end
				ST_ACK_THR: begin
					// newest acked entry sets the reference time
					thr_q    <= rd.stamp - STAMP_W'(window_q);
					thr_ok_q <= rd.stamp >= STAMP_W'(window_q);
				end
				ST_ACK_EV: begin
					if (expired_c) begin
						acked_b_q <= acked_b_q - BYTE_W'(rd.len);
						acked_p_q <= acked_p_q - 1'b1;
						awh_q     <= nxt(awh_q);
						if (age_awh > age_swh && rd.disc) begin
							disc_b_q <= disc_b_q - BYTE_W'(rd.len);
							disc_p_q <= disc_p_q - 1'b1;
						end
					end
				end
				ST_CH_BIT: begin
					if (!chunk_end_c) begin
						if (bv_q[bit_q]) begin
							bit_q <= bit_q + 1'b1;
							cur_q <= cur_q + 1'b1;
						end else begin
							// search in-flight entries first, then the acked window
							scan_q       <= fh_q;
							scan_acked_q <= 1'b0;
						end
					end
				end
				ST_CH_RD: begin
					if (!scan_acked_q && scan_q == wp_q) begin
						scan_q       <= awh_q;
						scan_acked_q <= 1'b1;
					end else if (scan_acked_q && scan_q == fh_q) begin
						bit_q <= bit_q + 1'b1;
						cur_q <= cur_q + 1'b1;
					end
				end
				ST_CH_EV: begin
					if (hit_c) begin
						bit_q <= bit_q + 1'b1;
						cur_q <= cur_q + 1'b1;
						if (mark_c) begin
							disc_b_q <= disc_b_q + BYTE_W'(rd.len);
							disc_p_q <= disc_p_q + 1'b1;
							hd_q     <= rd.seq;
						end
					end else begin
						scan_q <= nxt(scan_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free_c) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free_c) begin
			m_tdata_q <= {3'b000, ovf_q, acked_b_q - disc_b_q, disc_p_q, disc_b_q,
				flight_p_q, flight_b_q, acked_p_q, acked_b_q, sent_p_q, sent_b_q};
		end
	end

	`SPWT_ASSERT_ALWAYS(a_sent_live, age_swh <= PTR_W'(RING_DEPTH), "sent window overruns ring")
	`SPWT_ASSERT_ALWAYS(a_acked_live, age_awh <= PTR_W'(RING_DEPTH), "acked window overruns ring")
	`SPWT_ASSERT_ALWAYS(a_flight_order, age(wp_q, fh_q) <= age_awh, "flight head behind acked head")
	`SPWT_ASSERT_NEXT(a_add_adv, state_q == ST_DISPATCH && op_q == OP_ADD && !full_c, wp_q == nxt($past(wp_q)), "add did not advance write pointer")

endmodule
